[hw/rtl/mctmr_pkg.sv]
// shared constants, command codes and types of the periodic timer table
`default_nettype none
package mctmr_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
  localparam int RESULT_CAP = 8;
  localparam int CAP_W      = $clog2(RESULT_CAP + 1);
  localparam int QDEPTH     = 2;

  localparam logic [31:0] WORD_MAX = 32'hffff_ffff;

  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_START  = 3'd2;
  localparam logic [2:0] CMD_STOP   = 3'd3;
  localparam logic [2:0] CMD_QUERY  = 3'd4;
  localparam logic [2:0] CMD_TICK   = 3'd5;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  timer_id;
    logic [31:0] tag_in;
    logic [15:0] multiplier;
    logic [31:0] period_in;
    logic [31:0] now_ticks;
  } cmd_word_t;

  typedef struct packed {
    logic      valid;
    cmd_word_t word;
  } q_head_t;

  typedef struct packed {
    logic        valid;
    logic        status;
    logic [2:0]  slot_id;
    logic [31:0] remaining;
    logic        running;
    logic        expired;
    logic [31:0] expired_tag;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

[hw/rtl/mctmr_front.sv]
// command intake: drops unknown codes and queues words for the execution side
`default_nettype none
module mctmr_front (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  output logic                      busy,
  input  wire mctmr_pkg::cmd_word_t in_word,
  output mctmr_pkg::q_head_t        head,
  input  wire                       pop
);

  localparam int PTR_W = (mctmr_pkg::QDEPTH > 1) ? $clog2(mctmr_pkg::QDEPTH) : 1;
  localparam int QC_W  = $clog2(mctmr_pkg::QDEPTH + 1);

  mctmr_pkg::cmd_word_t q_r [mctmr_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]  count_r, count_nxt;
  logic             push;
  logic             do_pop;
  logic             known;

  assign busy   = (count_r == QC_W'(mctmr_pkg::QDEPTH));
  assign known  = (in_word.cmd <= mctmr_pkg::CMD_TICK);
  // unknown codes are taken and dropped here
  assign push   = start && !busy && known;
  assign do_pop = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.word  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(mctmr_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(mctmr_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_word;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mctmr_back.sv]
// execution side: slot tables, command handling and the tick walk over all slots
`default_nettype none
module mctmr_back (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire mctmr_pkg::q_head_t head,
  output logic                    pop,
  output mctmr_pkg::res_t         res
);

  localparam int N      = mctmr_pkg::NUM_TIMERS;
  localparam int SLOT_W = mctmr_pkg::SLOT_W;
  localparam int CNT_W  = mctmr_pkg::CNT_W;
  localparam int CAP_W  = mctmr_pkg::CAP_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_QUERY = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  // slot tables
  logic [31:0] tag_mem [N];
  logic [31:0] per_mem [N];
  logic [31:0] rem_mem [N];
  logic [31:0] tag_q, per_q, rem_q;
  logic        rem_ok_q;

  logic [2:0]        state_r, state_nxt;
  logic [2:0]        id_r, id_nxt;
  logic [47:0]       prod_r, prod_nxt;
  logic [31:0]       prev_r, prev_nxt;
  logic [31:0]       elapsed_r, elapsed_nxt;
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic [SLOT_W-1:0] chk_idx_r, chk_idx_nxt;
  logic [CAP_W-1:0]  n_r, n_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [SLOT_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [31:0]       pend_tag_r, pend_tag_nxt;
  logic [N-1:0]      used_r, used_nxt;
  logic [N-1:0]      rem_wv_r, rem_wv_nxt;
  mctmr_pkg::res_t   res_r, res_nxt;

  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] wr_addr;
  logic              tag_we, per_we, rem_we;
  logic [31:0]       wr_tag, wr_per, wr_rem;

  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] head_idx, id_idx;
  logic              head_ok, id_ok;
  logic [31:0]       rem_eff;
  logic [31:0]       sat_per;

  mctmr_pkg::cmd_word_t w;

  assign w        = head.word;
  assign head_idx = SLOT_W'(w.timer_id);
  assign head_ok  = (32'(w.timer_id) < 32'(N));
  assign id_idx   = SLOT_W'(id_r);
  assign id_ok    = (32'(id_r) < 32'(N));
  assign rem_eff  = rem_ok_q ? rem_q : 32'd0;
  assign sat_per  = (prod_r[47:32] != 16'd0) ? mctmr_pkg::WORD_MAX : prod_r[31:0];
  assign res      = res_r;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    id_nxt       = id_r;
    prod_nxt     = prod_r;
    prev_nxt     = prev_r;
    elapsed_nxt  = elapsed_r;
    issue_nxt    = issue_r;
    chk_v_nxt    = 1'b0;
    chk_idx_nxt  = chk_idx_r;
    n_nxt        = n_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    pend_tag_nxt = pend_tag_r;
    used_nxt     = used_r;
    rem_wv_nxt   = rem_wv_r;
    pop          = 1'b0;
    rd_addr      = head_idx;
    wr_addr      = head_idx;
    tag_we       = 1'b0;
    per_we       = 1'b0;
    rem_we       = 1'b0;
    wr_tag       = w.tag_in;
    wr_per       = 32'd0;
    wr_rem       = 32'd0;
    res_nxt      = '0;

    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop    = 1'b1;
          id_nxt = w.timer_id;
          case (w.cmd)
            mctmr_pkg::CMD_CREATE: begin
              res_nxt.valid = 1'b1;
              res_nxt.last  = 1'b1;
              if (free_found) begin
                wr_addr            = free_idx;
                tag_we             = 1'b1;
                per_we             = 1'b1;
                rem_we             = 1'b1;
                used_nxt[free_idx] = 1'b1;
                rem_wv_nxt[free_idx] = 1'b1;
                res_nxt.slot_id    = 3'(free_idx);
              end else begin
                res_nxt.status = 1'b1;
              end
            end
            mctmr_pkg::CMD_REMOVE: begin
              if (head_ok) begin
                used_nxt[head_idx] = 1'b0;
              end
              res_nxt.valid   = 1'b1;
              res_nxt.last    = 1'b1;
              res_nxt.slot_id = w.timer_id;
            end
            mctmr_pkg::CMD_START: begin
              prod_nxt  = 48'(w.multiplier) * 48'(w.period_in);
              state_nxt = ST_MUL;
            end
            mctmr_pkg::CMD_STOP: begin
              if (head_ok) begin
                per_we               = 1'b1;
                rem_we               = 1'b1;
                rem_wv_nxt[head_idx] = 1'b1;
              end
              res_nxt.valid   = 1'b1;
              res_nxt.last    = 1'b1;
              res_nxt.slot_id = w.timer_id;
            end
            mctmr_pkg::CMD_QUERY: begin
              state_nxt = ST_QUERY;
            end
            mctmr_pkg::CMD_TICK: begin
              if (w.now_ticks != prev_r) begin
                elapsed_nxt = w.now_ticks - prev_r;
                prev_nxt    = w.now_ticks;
                issue_nxt   = '0;
                n_nxt       = '0;
                pend_v_nxt  = 1'b0;
                state_nxt   = ST_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_MUL: begin
        wr_addr = id_idx;
        wr_per  = sat_per;
        wr_rem  = sat_per;
        if (id_ok) begin
          per_we             = 1'b1;
          rem_we             = 1'b1;
          rem_wv_nxt[id_idx] = 1'b1;
        end
        res_nxt.valid   = 1'b1;
        res_nxt.last    = 1'b1;
        res_nxt.slot_id = id_r;
        state_nxt       = ST_IDLE;
      end

      ST_QUERY: begin
        res_nxt.valid     = 1'b1;
        res_nxt.last      = 1'b1;
        res_nxt.slot_id   = id_r;
        res_nxt.remaining = id_ok ? rem_eff : 32'd0;
        res_nxt.running   = id_ok && used_r[id_idx] && (rem_eff != 32'd0);
        state_nxt         = ST_IDLE;
      end

      ST_WALK: begin
        // read one slot ahead while the previous one is checked and written back
        rd_addr = issue_r[SLOT_W-1:0];
        if (issue_r < CNT_W'(N)) begin
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = issue_r[SLOT_W-1:0];
          issue_nxt   = issue_r + 1'b1;
        end
        wr_addr = chk_idx_r;
        if (chk_v_r) begin
          if (used_r[chk_idx_r] && (rem_eff != 32'd0)) begin
            rem_we                = 1'b1;
            rem_wv_nxt[chk_idx_r] = 1'b1;
            if (rem_eff > elapsed_r) begin
              wr_rem = rem_eff - elapsed_r;
            end else begin
              wr_rem = per_q;
              if (n_r < CAP_W'(mctmr_pkg::RESULT_CAP)) begin
                // an earlier expiry goes out now that a later one exists
                if (pend_v_r) begin
                  res_nxt.valid       = 1'b1;
                  res_nxt.slot_id     = 3'(pend_idx_r);
                  res_nxt.expired     = 1'b1;
                  res_nxt.expired_tag = pend_tag_r;
                end
                pend_v_nxt   = 1'b1;
                pend_idx_nxt = chk_idx_r;
                pend_tag_nxt = tag_q;
                n_nxt        = n_r + 1'b1;
              end
            end
          end
          if (chk_idx_r == SLOT_W'(N - 1)) begin
            chk_v_nxt = 1'b0;
            state_nxt = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        if (pend_v_r) begin
          res_nxt.valid       = 1'b1;
          res_nxt.slot_id     = 3'(pend_idx_r);
          res_nxt.expired     = 1'b1;
          res_nxt.expired_tag = pend_tag_r;
          res_nxt.last        = 1'b1;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      prev_r    <= 32'd0;
      issue_r   <= '0;
      chk_v_r   <= 1'b0;
      n_r       <= '0;
      pend_v_r  <= 1'b0;
      used_r    <= '0;
      rem_wv_r  <= '0;
      res_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      prev_r    <= prev_nxt;
      issue_r   <= issue_nxt;
      chk_v_r   <= chk_v_nxt;
      n_r       <= n_nxt;
      pend_v_r  <= pend_v_nxt;
      used_r    <= used_nxt;
      rem_wv_r  <= rem_wv_nxt;
      res_r     <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    prod_r     <= prod_nxt;
    elapsed_r  <= elapsed_nxt;
    chk_idx_r  <= chk_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_tag_r <= pend_tag_nxt;
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[wr_addr] <= wr_tag;
    end
    if (per_we) begin
      per_mem[wr_addr] <= wr_per;
    end
    if (rem_we) begin
      rem_mem[wr_addr] <= wr_rem;
    end
    tag_q    <= tag_mem[rd_addr];
    per_q    <= per_mem[rd_addr];
    rem_q    <= rem_mem[rd_addr];
    rem_ok_q <= rem_wv_r[rd_addr];
  end

  a_cmd_result_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.valid && !res_r.expired |-> res_r.last)
    else $error("command result without last");

  a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CAP_W'(mctmr_pkg::RESULT_CAP))
    else $error("expiry count above cap");

  a_chk_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    chk_v_r |-> (state_r == ST_WALK))
    else $error("slot check outside tick walk");

  a_pend_counted: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (n_r != '0))
    else $error("pending expiry not counted");

  a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |=> (state_r == ST_IDLE))
    else $error("flush did not return to idle");

endmodule
`default_nettype wire

[hw/rtl/multi_channel_periodic_timer.sv]
// top level of the periodic timer table: command queue and execution side
//
// A command word is taken when start is high and busy is low; a two-word queue
// holds words while the execution side works, and busy is high only while that
// queue is full. Create, remove and stop are handled in the idle state, start and
// query in ST_MUL and ST_QUERY (the 16x32 multiply and the slot table read are
// registered). A tick whose value differs from the previous one walks all
// NUM_TIMERS slots through one table read port, one slot per cycle; an unchanged
// tick gives no word. Codes 6 and 7 are dropped at the queue. Each result word
// is shown for exactly one cycle with out_valid high and cannot be held off;
// expiry words of one tick come out in slot order, at most eight, with
// out_last on the final one, and every command word carries out_last.
`default_nettype none
module multi_channel_periodic_timer (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [2:0]  in_cmd,
  input  wire  [2:0]  in_timer_id,
  input  wire  [31:0] in_tag_in,
  input  wire  [15:0] in_multiplier,
  input  wire  [31:0] in_period_in,
  input  wire  [31:0] in_now_ticks,
  output logic        out_valid,
  output logic        out_status,
  output logic [2:0]  out_slot_id,
  output logic [31:0] out_remaining,
  output logic        out_running,
  output logic        out_expired,
  output logic [31:0] out_expired_tag,
  output logic        out_last
);

  mctmr_pkg::cmd_word_t in_word;
  mctmr_pkg::q_head_t   head;
  mctmr_pkg::res_t      res;
  logic                 pop;

  assign in_word.cmd        = in_cmd;
  assign in_word.timer_id   = in_timer_id;
  assign in_word.tag_in     = in_tag_in;
  assign in_word.multiplier = in_multiplier;
  assign in_word.period_in  = in_period_in;
  assign in_word.now_ticks  = in_now_ticks;

  mctmr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_word (in_word),
    .head    (head),
    .pop     (pop)
  );

  mctmr_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (head),
    .pop   (pop),
    .res   (res)
  );

  assign out_valid       = res.valid;
  assign out_status      = res.status;
  assign out_slot_id     = res.slot_id;
  assign out_remaining   = res.remaining;
  assign out_running     = res.running;
  assign out_expired     = res.expired;
  assign out_expired_tag = res.expired_tag;
  assign out_last        = res.last;

endmodule
`default_nettype wire

[tb/tb_multi_channel_periodic_timer.sv]
// self-checking regression of the periodic timer table: predicted words vs. block output

class timer_table_tracker;
  logic [mctmr_pkg::NUM_TIMERS-1:0] slot_busy;
  logic [31:0]           slot_tag_tbl    [mctmr_pkg::NUM_TIMERS];
  logic [31:0]           slot_period_tbl [mctmr_pkg::NUM_TIMERS];
  logic [31:0]           slot_count_tbl  [mctmr_pkg::NUM_TIMERS];
  logic [31:0]           prev_ticks;
  mctmr_pkg::res_t       awaited_words [$];
  int                    errors;

  function new();
    slot_busy  = '0;
    prev_ticks = '0;
    errors     = 0;
    for (int i = 0; i < mctmr_pkg::NUM_TIMERS; i++) begin
      slot_tag_tbl[i]    = '0;
      slot_period_tbl[i] = '0;
      slot_count_tbl[i]  = '0;
    end
  endfunction

  function void add_word(logic status, logic [2:0] slot, logic [31:0] remaining,
                         logic running, logic expired, logic [31:0] tag, logic last);
    mctmr_pkg::res_t w;
    w.valid       = 1'b1;
    w.status      = status;
    w.slot_id     = slot;
    w.remaining   = remaining;
    w.running     = running;
    w.expired     = expired;
    w.expired_tag = tag;
    w.last        = last;
    awaited_words.push_back(w);
  endfunction

  // update the table for one accepted command word and queue its answers
  function void note_word(mctmr_pkg::cmd_word_t c);
    logic        in_range;
    int          free_slot;
    int          hits;
    logic [47:0] product;
    logic [31:0] load;
    logic [31:0] elapsed;
    logic [31:0] count;
    in_range  = c.timer_id < mctmr_pkg::NUM_TIMERS;
    free_slot = -1;
    hits      = 0;
    case (c.cmd)
      mctmr_pkg::CMD_CREATE: begin
        for (int i = mctmr_pkg::NUM_TIMERS - 1; i >= 0; i--)
          if (!slot_busy[i]) free_slot = i;
        if (free_slot < 0) begin
          add_word(1'b1, 3'd0, '0, 1'b0, 1'b0, '0, 1'b1);
        end else begin
          slot_busy[free_slot]       = 1'b1;
          slot_tag_tbl[free_slot]    = c.tag_in;
          slot_period_tbl[free_slot] = '0;
          slot_count_tbl[free_slot]  = '0;
          add_word(1'b0, 3'(free_slot), '0, 1'b0, 1'b0, '0, 1'b1);
        end
      end
      mctmr_pkg::CMD_REMOVE: begin
        if (in_range) slot_busy[c.timer_id] = 1'b0;
        add_word(1'b0, c.timer_id, '0, 1'b0, 1'b0, '0, 1'b1);
      end
      mctmr_pkg::CMD_START: begin
        product = 48'(c.multiplier) * 48'(c.period_in);
        load    = (product > {16'b0, mctmr_pkg::WORD_MAX}) ? mctmr_pkg::WORD_MAX
                                                           : product[31:0];
        if (in_range) begin
          slot_period_tbl[c.timer_id] = load;
          slot_count_tbl[c.timer_id]  = load;
        end
        add_word(1'b0, c.timer_id, '0, 1'b0, 1'b0, '0, 1'b1);
      end
      mctmr_pkg::CMD_STOP: begin
        if (in_range) begin
          slot_period_tbl[c.timer_id] = '0;
          slot_count_tbl[c.timer_id]  = '0;
        end
        add_word(1'b0, c.timer_id, '0, 1'b0, 1'b0, '0, 1'b1);
      end
      mctmr_pkg::CMD_QUERY: begin
        count = in_range ? slot_count_tbl[c.timer_id] : '0;
        add_word(1'b0, c.timer_id, count,
                 in_range && slot_busy[c.timer_id] && count != 0, 1'b0, '0, 1'b1);
      end
      mctmr_pkg::CMD_TICK: begin
        if (c.now_ticks != prev_ticks) begin
          // modular difference, so a wrap of the tick counter is a small step
          elapsed    = c.now_ticks - prev_ticks;
          prev_ticks = c.now_ticks;
          for (int i = 0; i < mctmr_pkg::NUM_TIMERS; i++) begin
            if (slot_busy[i] && slot_count_tbl[i] != 0) begin
              if (slot_count_tbl[i] > elapsed) begin
                slot_count_tbl[i] = slot_count_tbl[i] - elapsed;
              end else begin
                slot_count_tbl[i] = slot_period_tbl[i];
                if (hits < mctmr_pkg::RESULT_CAP) begin
                  add_word(1'b0, 3'(i), '0, 1'b0, 1'b1, slot_tag_tbl[i], 1'b0);
                  hits++;
                end
              end
            end
          end
          if (hits > 0) awaited_words[awaited_words.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      errors++;
    end
  endfunction

  function void check_word(mctmr_pkg::res_t got);
    mctmr_pkg::res_t want;
    if (awaited_words.size() == 0) begin
      $display("%0t: unexpected word, expected none actual slot %0d expired %0b tag %h",
               $time, got.slot_id, got.expired, got.expired_tag);
      errors++;
      return;
    end
    want = awaited_words.pop_front();
    compare_field("status", 32'(want.status), 32'(got.status));
    compare_field("slot_id", 32'(want.slot_id), 32'(got.slot_id));
    compare_field("remaining", want.remaining, got.remaining);
    compare_field("running", 32'(want.running), 32'(got.running));
    compare_field("expired", 32'(want.expired), 32'(got.expired));
    compare_field("expired_tag", want.expired_tag, got.expired_tag);
    compare_field("last", 32'(want.last), 32'(got.last));
  endfunction

  function int pending();
    return awaited_words.size();
  endfunction
endclass

module tb_multi_channel_periodic_timer;
  localparam logic [2:0] CMD_RSVD_A  = 3'd6;
  localparam logic [2:0] CMD_RSVD_B  = 3'd7;
  localparam int         ITEM_TARGET = 450;
  localparam int         DRAIN_WAIT  = 4 * (mctmr_pkg::NUM_TIMERS + 2);

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        start           = 1'b0;
  logic [2:0]  in_cmd          = mctmr_pkg::CMD_QUERY;
  logic [2:0]  in_timer_id     = '0;
  logic [31:0] in_tag_in       = '0;
  logic [15:0] in_multiplier   = '0;
  logic [31:0] in_period_in    = '0;
  logic [31:0] in_now_ticks    = '0;
  logic        busy;
  logic        out_valid;
  logic        out_status;
  logic [2:0]  out_slot_id;
  logic [31:0] out_remaining;
  logic        out_running;
  logic        out_expired;
  logic [31:0] out_expired_tag;
  logic        out_last;

  timer_table_tracker tracker = new();
  logic [31:0]        tick_now   = '0;
  int                 items_sent = 0;
  int                 idle_pct   = 0;

  multi_channel_periodic_timer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_timer_id    (in_timer_id),
    .in_tag_in      (in_tag_in),
    .in_multiplier  (in_multiplier),
    .in_period_in   (in_period_in),
    .in_now_ticks   (in_now_ticks),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_slot_id    (out_slot_id),
    .out_remaining  (out_remaining),
    .out_running    (out_running),
    .out_expired    (out_expired),
    .out_expired_tag(out_expired_tag),
    .out_last       (out_last)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin : monitor
    mctmr_pkg::cmd_word_t taken;
    mctmr_pkg::res_t      seen;
    if (rst_n && out_valid) begin
      seen = {1'b1, out_status, out_slot_id, out_remaining, out_running, out_expired,
              out_expired_tag, out_last};
      tracker.check_word(seen);
    end
    if (rst_n && start && !busy) begin
      taken = {in_cmd, in_timer_id, in_tag_in, in_multiplier, in_period_in, in_now_ticks};
      tracker.note_word(taken);
    end
  end

  // returns at the edge that takes the word, start still high
  task automatic send_word(input logic [2:0] cmd, input logic [2:0] id,
                           input logic [31:0] tag, input logic [15:0] mult,
                           input logic [31:0] per, input logic [31:0] now);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_timer_id   <= id;
    in_tag_in     <= tag;
    in_multiplier <= mult;
    in_period_in  <= per;
    in_now_ticks  <= now;
    do @(posedge clk); while (busy);
    if (cmd <= mctmr_pkg::CMD_TICK) items_sent++;
  endtask

  task automatic send_cmd(input logic [2:0] cmd, input logic [2:0] id,
                          input logic [15:0] mult, input logic [31:0] per);
    send_word(cmd, id, $urandom(), mult, per, $urandom());
  endtask

  task automatic send_tick(input logic [31:0] delta);
    tick_now = tick_now + delta;
    send_word(mctmr_pkg::CMD_TICK, 3'($urandom()), $urandom(), 16'($urandom()), $urandom(),
              tick_now);
  endtask

  task automatic send_random_tick();
    int pick;
    pick = $urandom_range(99);
    if (pick < 80)      send_tick(32'($urandom_range(1, 8)));
    else if (pick < 88) send_tick(32'd0);
    else                send_tick($urandom());
  endtask

  task automatic send_random_start();
    int          pick;
    logic [15:0] mult;
    logic [31:0] per;
    pick = $urandom_range(99);
    mult = 16'($urandom_range(1, 4));
    per  = 32'($urandom_range(1, 20));
    if (pick >= 95)      per  = '0;
    else if (pick >= 90) mult = '0;
    else if (pick >= 80) begin
      mult = 16'($urandom());
      per  = $urandom();
    end
    send_cmd(mctmr_pkg::CMD_START, 3'($urandom()), mult, per);
  endtask

  // create three timers, arm every slot with a short period, then let every used slot fire
  task automatic expiry_burst();
    repeat (3) send_cmd(mctmr_pkg::CMD_CREATE, 3'($urandom()), 16'($urandom()), $urandom());
    for (int s = 0; s < mctmr_pkg::NUM_TIMERS; s++)
      send_cmd(mctmr_pkg::CMD_START, 3'(s), 16'd1, 32'($urandom_range(1, 3)));
    send_tick(32'd3);
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 12)
      send_cmd(mctmr_pkg::CMD_CREATE, 3'($urandom()), 16'($urandom()), $urandom());
    else if (pick < 20)
      send_cmd(mctmr_pkg::CMD_REMOVE, 3'($urandom()), 16'($urandom()), $urandom());
    else if (pick < 40)
      send_random_start();
    else if (pick < 45)
      send_cmd(mctmr_pkg::CMD_STOP, 3'($urandom()), 16'($urandom()), $urandom());
    else if (pick < 62)
      send_cmd(mctmr_pkg::CMD_QUERY, 3'($urandom()), 16'($urandom()), $urandom());
    else if (pick < 96)
      send_random_tick();
    else
      send_cmd(pick[0] ? CMD_RSVD_A : CMD_RSVD_B, 3'($urandom()),
               16'($urandom()), $urandom());
  endtask

  initial begin
    int phase_pct [4];
    phase_pct = '{0, 49, 0, 35};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state, full table, extremes of the period, wrap of the tick counter
    send_cmd(mctmr_pkg::CMD_QUERY, 3'd0, 16'hffff, 32'hffff_ffff);
    send_tick(32'd0);
    for (int s = 0; s < mctmr_pkg::NUM_TIMERS; s++)
      send_word(mctmr_pkg::CMD_CREATE, 3'd7,
                (s == 0) ? 32'd0 : (s == 1) ? 32'hffff_ffff : $urandom(),
                16'($urandom()), $urandom(), $urandom());
    send_cmd(mctmr_pkg::CMD_CREATE, 3'd0, 16'd0, 32'd0);
    send_cmd(mctmr_pkg::CMD_START, 3'd0, 16'hffff, 32'hffff_ffff);
    send_cmd(mctmr_pkg::CMD_START, 3'd1, 16'd0, 32'hffff_ffff);
    send_cmd(mctmr_pkg::CMD_START, 3'd2, 16'd1, 32'd1);
    send_cmd(mctmr_pkg::CMD_START, 3'd3, 16'd1, 32'd3);
    send_cmd(mctmr_pkg::CMD_START, 3'd4, 16'd2, 32'd2);
    send_cmd(mctmr_pkg::CMD_QUERY, 3'd0, 16'd0, 32'd0);
    send_cmd(mctmr_pkg::CMD_QUERY, 3'd1, 16'd0, 32'd0);
    send_cmd(mctmr_pkg::CMD_STOP, 3'd4, 16'd0, 32'd0);
    send_cmd(mctmr_pkg::CMD_REMOVE, 3'd5, 16'd0, 32'd0);
    send_cmd(mctmr_pkg::CMD_START, 3'd5, 16'd1, 32'd1);
    send_tick(32'd1);
    send_tick(32'd3);
    send_tick(32'hffff_fffb);
    send_cmd(CMD_RSVD_A, 3'd6, 16'hffff, 32'hffff_ffff);
    send_cmd(CMD_RSVD_B, 3'd7, 16'hffff, 32'hffff_ffff);
    send_cmd(mctmr_pkg::CMD_CREATE, 3'd7, 16'd0, 32'd0);
    send_tick(32'd3);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = phase_pct[phase];
      while (items_sent < (phase + 1) * ITEM_TARGET / 4) begin
        if ($urandom_range(99) < 4) expiry_burst();
        else                        random_item();
      end
    end
    start <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("multi_channel_periodic_timer regression: pass");
    end else begin
      $display("multi_channel_periodic_timer regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("multi_channel_periodic_timer regression: fail");
    $finish;
  end
endmodule

[files.f]
hw/rtl/mctmr_pkg.sv
hw/rtl/mctmr_front.sv
hw/rtl/mctmr_back.sv
hw/rtl/multi_channel_periodic_timer.sv
tb/tb_multi_channel_periodic_timer.sv
